>>> design/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types, sizes and character codes of the tape machine.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int TAPE_DEPTH = 32768;
  localparam int PROG_DEPTH = 4096;

  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int PROG_AW = $clog2(PROG_DEPTH);
  localparam int PC_W    = $clog2(PROG_DEPTH + 1);

  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_STEP    = 2'd1,
    REQ_RESTART = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNKNOWN = 2'd1,
    ERR_BRACKET = 2'd2,
    ERR_FULL    = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_LOAD,
    SRC_EXEC,
    SRC_SEEK
  } res_src_t;

  typedef enum logic [2:0] {
    S_WIPE,
    S_IDLE,
    S_EXEC,
    S_FWD,
    S_BWD,
    S_RESTART,
    S_RESP
  } state_t;

  typedef struct packed {
    logic     load_char;
    logic     take_byte;
    logic     restart;
    logic     clear;
    logic     exec;
    logic     seek_fwd;
    logic     seek_bwd;
    logic     out_fresh;
    logic     capture;
    logic     out_pend;
    res_src_t src;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic halted;
    logic clr_last;
    logic need_fwd;
    logic need_bwd;
    logic fwd_done;
    logic bwd_done;
  } dp_status_t;

endpackage

>>> design/bfm_req_if.sv
// ----------------------------------------------------------------------------
// bfm_req_if
// Request channel: load, step or restart with its payload.
// ----------------------------------------------------------------------------
interface bfm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] prog_char;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output prog_char, output in_byte,
                  input ready);
  modport sink (input valid, input req_type, input prog_char, input in_byte,
                output ready);
endinterface

>>> design/bfm_rsp_if.sv
// ----------------------------------------------------------------------------
// bfm_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface bfm_rsp_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       halted;
  logic [1:0] error_code;

  modport source (output valid, output out_valid, output out_byte, output halted,
                  output error_code, input ready);
  modport sink (input valid, input out_valid, input out_byte, input halted,
                input error_code, output ready);
endinterface

>>> design/bfm_ram.sv
// ----------------------------------------------------------------------------
// bfm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> design/bfm_dp.sv
// ----------------------------------------------------------------------------
// bfm_dp
// Datapath: program and tape memories, counters, bracket walk, result register.
// ----------------------------------------------------------------------------
module bfm_dp import bfm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  st,
  input  logic [7:0]  prog_char,
  input  logic [7:0]  in_byte,
  bfm_rsp_if.source   rsp
);

  logic [PC_W-1:0]    len, len_next;
  logic [PC_W-1:0]    pc, pc_next;
  logic [TAPE_AW-1:0] ptr;
  logic [TAPE_AW-1:0] clr_addr;
  logic [PC_W-1:0]    k;
  logic [PC_W-1:0]    depth;
  logic [7:0]         byte_in;

  logic               pend_print;
  logic [7:0]         pend_byte;
  err_code_t          pend_err;

  logic               rsp_valid;
  logic               rsp_print;
  logic [7:0]         rsp_byte;
  logic               rsp_halted;
  err_code_t          rsp_err;

  logic [7:0]         op, cur_cell;
  logic               prog_we, tape_we, full;
  logic [PROG_AW-1:0] prog_raddr;
  logic [7:0]         tape_wdata;
  logic               is_open, is_close, known;
  logic               need_fwd, need_bwd, bwd_fail;
  logic               fwd_hit, fwd_miss, bwd_hit, bwd_miss;
  logic [PC_W-1:0]    pc_inc, pc_dec, k_inc, k_dec;
  logic               fresh_print, fresh_halted;
  err_code_t          fresh_err;

  assign full    = (len == PC_W'(PROG_DEPTH));
  assign prog_we = cmd.load_char && !full;

  assign pc_inc = pc + PC_W'(1);
  assign pc_dec = pc - PC_W'(1);
  assign k_inc  = k + PC_W'(1);
  assign k_dec  = k - PC_W'(1);

  always_comb begin
    if (cmd.seek_fwd) begin
      prog_raddr = k_inc[PROG_AW-1:0];
    end else if (cmd.seek_bwd) begin
      prog_raddr = k_dec[PROG_AW-1:0];
    end else if (cmd.exec) begin
      prog_raddr = (op == CH_OPEN) ? pc_inc[PROG_AW-1:0] : pc_dec[PROG_AW-1:0];
    end else begin
      prog_raddr = pc[PROG_AW-1:0];
    end
  end

  bfm_ram #(.DEPTH(PROG_DEPTH), .WIDTH(8)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (len[PROG_AW-1:0]),
    .wdata (prog_char),
    .raddr (prog_raddr),
    .rdata (op)
  );

  always_comb begin
    case (op)
      CH_INC:  tape_wdata = cur_cell + 8'd1;
      CH_DEC:  tape_wdata = cur_cell - 8'd1;
      default: tape_wdata = byte_in;
    endcase
    if (cmd.clear) begin
      tape_wdata = '0;
    end
  end

  assign tape_we = cmd.clear ||
                   (cmd.exec && (op == CH_INC || op == CH_DEC || op == CH_IN));

  bfm_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (cmd.clear ? clr_addr : ptr),
    .wdata (tape_wdata),
    .raddr (ptr),
    .rdata (cur_cell)
  );

  // instruction decode
  assign is_open  = (op == CH_OPEN);
  assign is_close = (op == CH_CLOSE);
  assign known    = (op == CH_INC) || (op == CH_DEC) || (op == CH_RIGHT) ||
                    (op == CH_LEFT) || is_open || is_close || (op == CH_OUT) ||
                    (op == CH_IN);
  assign need_fwd = is_open && (cur_cell == 8'd0);
  assign need_bwd = is_close && (cur_cell != 8'd0) && (pc != '0);
  assign bwd_fail = is_close && (cur_cell != 8'd0) && (pc == '0);

  // bracket walk
  assign fwd_miss = (k >= len);
  assign fwd_hit  = !fwd_miss && is_close && (depth == '0);
  assign bwd_hit  = is_open && (depth == '0);
  assign bwd_miss = !bwd_hit && (k == '0);

  always_comb begin
    pc_next = pc;
    if (cmd.restart) begin
      pc_next = '0;
    end else if (cmd.exec) begin
      if (bwd_fail) begin
        pc_next = len;
      end else if (!need_fwd && !need_bwd) begin
        pc_next = pc_inc;
      end
    end else if (cmd.seek_fwd) begin
      if (fwd_miss) begin
        pc_next = len;
      end else if (fwd_hit) begin
        pc_next = k_inc;
      end
    end else if (cmd.seek_bwd) begin
      if (bwd_hit) begin
        pc_next = k_inc;
      end else if (bwd_miss) begin
        pc_next = len;
      end
    end
  end

  assign len_next = prog_we ? len + PC_W'(1) : len;

  always_comb begin
    case (cmd.src)
      SRC_LOAD: fresh_err = full ? ERR_FULL : ERR_NONE;
      SRC_EXEC: fresh_err = !known ? ERR_UNKNOWN : (bwd_fail ? ERR_BRACKET : ERR_NONE);
      SRC_SEEK: fresh_err = (cmd.seek_fwd ? fwd_miss : bwd_miss) ? ERR_BRACKET : ERR_NONE;
      default:  fresh_err = ERR_NONE;
    endcase
  end

  assign fresh_print  = (cmd.src == SRC_EXEC) && (op == CH_OUT);
  assign fresh_halted = (pc_next >= len_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      pc       <= '0;
      ptr      <= '0;
      clr_addr <= '0;
    end else begin
      len <= len_next;
      pc  <= pc_next;
      if (cmd.restart) begin
        ptr      <= '0;
        clr_addr <= '0;
      end else begin
        if (cmd.exec && op == CH_RIGHT) begin
          ptr <= (ptr == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : ptr + TAPE_AW'(1);
        end else if (cmd.exec && op == CH_LEFT) begin
          ptr <= (ptr == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : ptr - TAPE_AW'(1);
        end
        if (cmd.clear) begin
          clr_addr <= st.clr_last ? '0 : clr_addr + TAPE_AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      byte_in <= in_byte;
    end
    if (cmd.exec) begin
      if (need_fwd) begin
        k     <= pc_inc;
        depth <= '0;
      end else if (need_bwd) begin
        k     <= pc_dec;
        depth <= '0;
      end
    end else if (cmd.seek_fwd) begin
      k <= k_inc;
      if (is_open) begin
        depth <= depth + PC_W'(1);
      end else if (is_close && depth != '0) begin
        depth <= depth - PC_W'(1);
      end
    end else if (cmd.seek_bwd) begin
      k <= k_dec;
      if (is_close) begin
        depth <= depth + PC_W'(1);
      end else if (is_open && depth != '0) begin
        depth <= depth - PC_W'(1);
      end
    end
    if (cmd.capture) begin
      pend_print <= fresh_print;
      pend_byte  <= fresh_print ? cur_cell : 8'd0;
      pend_err   <= fresh_err;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_fresh || cmd.out_pend) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fresh) begin
      rsp_print  <= fresh_print;
      rsp_byte   <= fresh_print ? cur_cell : 8'd0;
      rsp_halted <= fresh_halted;
      rsp_err    <= fresh_err;
    end else if (cmd.out_pend) begin
      rsp_print  <= pend_print;
      rsp_byte   <= pend_byte;
      rsp_halted <= (pc >= len);
      rsp_err    <= pend_err;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.out_valid  = rsp_print;
  assign rsp.out_byte   = rsp_byte;
  assign rsp.halted     = rsp_halted;
  assign rsp.error_code = rsp_err;

  assign st.out_free = !rsp_valid || rsp.ready;
  assign st.halted   = (pc >= len);
  assign st.clr_last = (clr_addr == TAPE_AW'(TAPE_DEPTH - 1));
  assign st.need_fwd = need_fwd;
  assign st.need_bwd = need_bwd;
  assign st.fwd_done = fwd_hit || fwd_miss;
  assign st.bwd_done = bwd_hit || bwd_miss;

  a_pc_bound: assert property (@(posedge clk) disable iff (rst) pc <= len)
    else $error("program counter beyond program end");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= PC_W'(PROG_DEPTH))
    else $error("program length beyond program memory");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_print |-> rsp_byte == 8'd0)
    else $error("output byte set without print");

endmodule

>>> design/bfm_ctrl.sv
// ----------------------------------------------------------------------------
// bfm_ctrl
// Controller: request decode, instruction sequencing, bracket walk, clearing.
// ----------------------------------------------------------------------------
module bfm_ctrl import bfm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  bfm_req_if.sink    req,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;
  logic   accept;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.src    = SRC_NONE;
    state_next = state;
    case (state)
      S_WIPE: begin
        cmd.clear = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_LOAD: begin
              cmd.load_char = 1'b1;
              cmd.src       = SRC_LOAD;
              if (st.out_free) begin
                cmd.out_fresh = 1'b1;
              end else begin
                cmd.capture = 1'b1;
                state_next  = S_RESP;
              end
            end
            REQ_STEP: begin
              cmd.take_byte = 1'b1;
              if (!st.halted) begin
                state_next = S_EXEC;
              end else if (st.out_free) begin
                cmd.out_fresh = 1'b1;
              end else begin
                cmd.capture = 1'b1;
                state_next  = S_RESP;
              end
            end
            REQ_RESTART: begin
              cmd.restart = 1'b1;
              cmd.capture = 1'b1;
              state_next  = S_RESTART;
            end
            default: begin
              if (st.out_free) begin
                cmd.out_fresh = 1'b1;
              end else begin
                cmd.capture = 1'b1;
                state_next  = S_RESP;
              end
            end
          endcase
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        cmd.src  = SRC_EXEC;
        if (st.need_fwd) begin
          state_next = S_FWD;
        end else if (st.need_bwd) begin
          state_next = S_BWD;
        end else if (st.out_free) begin
          cmd.out_fresh = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.capture = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_FWD: begin
        cmd.seek_fwd = 1'b1;
        cmd.src      = SRC_SEEK;
        if (st.fwd_done) begin
          if (st.out_free) begin
            cmd.out_fresh = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_RESP;
          end
        end
      end
      S_BWD: begin
        cmd.seek_bwd = 1'b1;
        cmd.src      = SRC_SEEK;
        if (st.bwd_done) begin
          if (st.out_free) begin
            cmd.out_fresh = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_RESP;
          end
        end
      end
      S_RESTART: begin
        cmd.clear = 1'b1;
        if (st.clr_last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.out_pend = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == REQ_RESTART |=> state == S_RESTART)
    else $error("restart did not start the tape clear");

endmodule

>>> design/brainfuck_machine.sv
// ----------------------------------------------------------------------------
// brainfuck_machine
// Eight-command tape machine with program memory and a 32K-cell tape.
// ----------------------------------------------------------------------------
//  channel  modport  payload
//  req      sink     req_type, prog_char, in_byte
//  rsp      source   out_valid, out_byte, halted, error_code
//
//  load: answered straight from idle; step: run in the exec state, plus a walk
//  of the program when a bracket jumps (one program memory read a cycle);
//  halted step: answered from idle. restart: clears all 32768 tape cells,
//  one cell a cycle; after reset that clear runs before the first transfer.
//  a registered result lets the next request in while it waits; a new result
//  waits until the result register is free.
// ----------------------------------------------------------------------------
module brainfuck_machine import bfm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  bfm_req_if.sink   req,
  bfm_rsp_if.source rsp
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  bfm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .req (req),
    .st  (st),
    .cmd (cmd)
  );

  bfm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .prog_char (req.prog_char),
    .in_byte   (req.in_byte),
    .rsp       (rsp)
  );

endmodule
